FILE: hw/rtl/uct_pkg.sv
// Package for the user credential table: sizes, request codes, preset strings.
`timescale 1ns / 1ps
`default_nettype none

package uct_pkg;

  localparam int NumEntries = 10;
  localparam int IdxW       = (NumEntries > 1) ? $clog2(NumEntries) : 1;

  localparam logic [63:0] StrRoot    = 64'h726F6F7400000000;
  localparam logic [63:0] StrToor    = 64'h746F6F7200000000;
  localparam logic [63:0] StrUser    = 64'h7573657200000000;
  localparam logic [63:0] StrUnknown = 64'h756E6B6E6F776E00;
  localparam logic [15:0] UidRoot    = 16'd0;
  localparam logic [15:0] UidUser    = 16'd1000;

  typedef enum logic [1:0] {
    REQ_CHECK  = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_ADD    = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  // clear every byte after the first zero byte, byte 0 in the top bits
  function automatic logic [255:0] str_norm(input logic [255:0] s);
    logic         ended;
    logic [255:0] r;
    ended = 1'b0;
    r     = s;
    for (int b = 0; b < 32; b++) begin
      if (ended) begin
        r[255-8*b -: 8] = 8'h00;
      end else if (s[255-8*b -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/user_credential_table_top.sv
// Credential table top level: request sequencer, entry store and entry compare unit.
//
//  channel | dir | handshake               | beat payload
//  --------+-----+-------------------------+----------------------------------------------
//  in      | in  | in_valid_i / in_stall_o | req_type, name_hi/lo, pass_w0..3, uid, gid
//  out     | out | out_valid_o/ out_stall_i| status, found_uid, out_name_hi/lo
//
//  One beat per request. The request is latched and normalized in the accept cycle, then one
//  entry is compared per cycle, stopping at the first hit or after the last entry.
//  The result is held in the output register until taken; in_stall_o is high from accept
//  until the result beat leaves, so no new request is taken while one is in flight, and the
//  next request can be taken in the cycle after the result beat leaves.
//  Reset (async, active low) preloads entry 0 as root and entry 1 as user.
`timescale 1ns / 1ps
`default_nettype none

module user_credential_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [63:0] name_hi_i,
  input  wire logic [63:0] name_lo_i,
  input  wire logic [63:0] pass_w0_i,
  input  wire logic [63:0] pass_w1_i,
  input  wire logic [63:0] pass_w2_i,
  input  wire logic [63:0] pass_w3_i,
  input  wire logic [15:0] user_id_i,
  input  wire logic [15:0] group_id_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic [15:0]      found_uid_o,
  output logic [63:0]      out_name_hi_o,
  output logic [63:0]      out_name_lo_o
);
  import uct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  req_e        req_q;
  logic [63:0] rname_hi_q, rname_lo_q;
  logic [63:0] rpass_q [4];
  logic [15:0] ruid_q, rgid_q;

  logic        ent_valid_q   [NumEntries];
  logic [15:0] ent_uid_q     [NumEntries];
  logic [15:0] ent_gid_q     [NumEntries];
  logic [63:0] ent_name_hi_q [NumEntries];
  logic [63:0] ent_name_lo_q [NumEntries];
  logic [63:0] ent_pass_q    [NumEntries][4];

  logic        status_q, status_d;
  logic [15:0] fuid_q, fuid_d;
  logic [63:0] ohi_q, ohi_d, olo_q, olo_d;

  logic [255:0] pass_norm;
  logic [127:0] name_norm;
  logic         accept, last, name_eq, pass_eq, uid_eq, cur_valid;
  logic         wr_en, clr_en;

  assign accept = in_valid_i && !in_stall_o;
  assign last   = (idx_q == IdxW'(NumEntries - 1));

  assign pass_norm = str_norm({pass_w0_i, pass_w1_i, pass_w2_i, pass_w3_i});
  always_comb begin
    logic [255:0] t;
    t         = str_norm({name_hi_i, name_lo_i, 128'd0});
    name_norm = t[255:128];
  end

  // shared entry compare unit, one entry per cycle
  assign cur_valid = ent_valid_q[idx_q];
  assign name_eq   = cur_valid && (ent_name_hi_q[idx_q] == rname_hi_q)
                     && (ent_name_lo_q[idx_q] == rname_lo_q);
  assign pass_eq   = (ent_pass_q[idx_q][0] == rpass_q[0]) && (ent_pass_q[idx_q][1] == rpass_q[1])
                     && (ent_pass_q[idx_q][2] == rpass_q[2])
                     && (ent_pass_q[idx_q][3] == rpass_q[3]);
  assign uid_eq    = cur_valid && (ent_uid_q[idx_q] == ruid_q);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    status_d = status_q;
    fuid_d   = fuid_q;
    ohi_d    = ohi_q;
    olo_d    = olo_q;
    wr_en    = 1'b0;
    clr_en   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        logic hit;
        hit      = 1'b0;
        status_d = 1'b1;
        fuid_d   = '0;
        ohi_d    = '0;
        olo_d    = '0;
        unique case (req_q)
          REQ_CHECK: begin
            hit = name_eq;
            if (name_eq && pass_eq) begin
              status_d = 1'b0;
              fuid_d   = ent_uid_q[idx_q];
            end
          end
          REQ_LOOKUP: begin
            hit   = uid_eq;
            ohi_d = StrUnknown;
            if (uid_eq) begin
              status_d = 1'b0;
              ohi_d    = ent_name_hi_q[idx_q];
              olo_d    = ent_name_lo_q[idx_q];
            end
          end
          REQ_ADD: begin
            hit = !cur_valid;
            if (!cur_valid) begin
              status_d = 1'b0;
              wr_en    = 1'b1;
            end
          end
          REQ_DELETE: begin
            hit = name_eq;
            if (name_eq && (ent_uid_q[idx_q] != UidRoot)) begin
              status_d = 1'b0;
              clr_en   = 1'b1;
            end
          end
          default: hit = 1'b1;
        endcase
        if (hit || last) begin
          state_d = S_OUT;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_e'(req_type_i);
      rname_hi_q <= name_norm[127:64];
      rname_lo_q <= name_norm[63:0];
      rpass_q[0] <= pass_norm[255:192];
      rpass_q[1] <= pass_norm[191:128];
      rpass_q[2] <= pass_norm[127:64];
      rpass_q[3] <= pass_norm[63:0];
      ruid_q     <= user_id_i;
      rgid_q     <= group_id_i;
    end
    status_q <= status_d;
    fuid_q   <= fuid_d;
    ohi_q    <= ohi_d;
    olo_q    <= olo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < NumEntries; e++) begin
        ent_valid_q[e]   <= 1'b0;
        ent_uid_q[e]     <= '0;
        ent_gid_q[e]     <= '0;
        ent_name_hi_q[e] <= '0;
        ent_name_lo_q[e] <= '0;
        for (int w = 0; w < 4; w++) ent_pass_q[e][w] <= '0;
      end
      ent_valid_q[0]   <= 1'b1;
      ent_name_hi_q[0] <= StrRoot;
      ent_pass_q[0][0] <= StrToor;
      ent_valid_q[1]   <= 1'b1;
      ent_uid_q[1]     <= UidUser;
      ent_gid_q[1]     <= UidUser;
      ent_name_hi_q[1] <= StrUser;
      ent_pass_q[1][0] <= StrUser;
    end else if (wr_en) begin
      ent_valid_q[idx_q]   <= 1'b1;
      ent_uid_q[idx_q]     <= ruid_q;
      ent_gid_q[idx_q]     <= rgid_q;
      ent_name_hi_q[idx_q] <= rname_hi_q;
      ent_name_lo_q[idx_q] <= {rname_lo_q[63:8], 8'h00};
      ent_pass_q[idx_q][0] <= rpass_q[0];
      ent_pass_q[idx_q][1] <= rpass_q[1];
      ent_pass_q[idx_q][2] <= rpass_q[2];
      ent_pass_q[idx_q][3] <= {rpass_q[3][63:8], 8'h00};
    end else if (clr_en) begin
      ent_valid_q[idx_q] <= 1'b0;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = status_q;
  assign found_uid_o   = fuid_q;
  assign out_name_hi_o = ohi_q;
  assign out_name_lo_o = olo_q;

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN) && (idx_q == '0)) else $error("scan did not start");
  a_uid_only_on_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (found_uid_o != '0)) |-> (status_o == 1'b0))
    else $error("uid on failed result");
  a_single_store_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en || clr_en) |-> ((state_q == S_SCAN) && !(wr_en && clr_en)))
    else $error("store op outside scan");
`endif

endmodule

`default_nettype wire

FILE: verif/user_credential_table_top_test.sv
// Self-checking testbench for the user credential table: directed table, random requests.
`timescale 1ns / 1ps

module user_credential_table_top_test;
  import uct_pkg::*;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  localparam logic [63:0] TXT_ROOT    = 64'h726F6F7400000000;
  localparam logic [63:0] TXT_TOOR    = 64'h746F6F7200000000;
  localparam logic [63:0] TXT_USER    = 64'h7573657200000000;
  localparam logic [63:0] TXT_UNKNOWN = 64'h756E6B6E6F776E00;

  localparam int RANDOM_BEATS = 400;
  localparam int QUIET_FROM   = 200;
  localparam int QUIET_TO     = 300;
  localparam int HOLD_AT      = 80;
  localparam int HOLD_CYCLES  = 250;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    req_e         kind;
    logic [127:0] name;
    logic [255:0] pass;
    logic [15:0]  uid;
    logic [15:0]  gid;
  } cred_req_t;

  typedef struct {
    logic         status;
    logic [15:0]  uid;
    logic [127:0] name;
  } cred_reply_t;

  typedef struct {
    cred_req_t   rq;
    bit          typed;
    cred_reply_t want;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [63:0] name_hi_i;
  logic [63:0] name_lo_i;
  logic [63:0] pass_w0_i;
  logic [63:0] pass_w1_i;
  logic [63:0] pass_w2_i;
  logic [63:0] pass_w3_i;
  logic [15:0] user_id_i;
  logic [15:0] group_id_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_o;
  logic [15:0] found_uid_o;
  logic [63:0] out_name_hi_o;
  logic [63:0] out_name_lo_o;

  // shadow copy of the account table
  logic         acct_used [NumEntries];
  logic [15:0]  acct_uid  [NumEntries];
  logic [15:0]  acct_gid  [NumEntries];
  logic [127:0] acct_name [NumEntries];
  logic [255:0] acct_pass [NumEntries];

  cred_reply_t awaited_replies [$];
  plan_row_t   plan [$];
  int          offered_cnt  = 0;
  int          mismatch_cnt = 0;
  int          cycle_cnt    = 0;
  int          hold_left    = 0;
  bit          held_once    = 1'b0;

  user_credential_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .name_hi_i     (name_hi_i),
    .name_lo_i     (name_lo_i),
    .pass_w0_i     (pass_w0_i),
    .pass_w1_i     (pass_w1_i),
    .pass_w2_i     (pass_w2_i),
    .pass_w3_i     (pass_w3_i),
    .user_id_i     (user_id_i),
    .group_id_i    (group_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_uid_o   (found_uid_o),
    .out_name_hi_o (out_name_hi_o),
    .out_name_lo_o (out_name_lo_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit calm();
    return offered_cnt >= QUIET_FROM && offered_cnt < QUIET_TO;
  endfunction

  function automatic logic [127:0] name_of(input string s);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  function automatic logic [255:0] secret_of(input string s);
    logic [255:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 32; i++) r[255-8*i -: 8] = s[i];
    return r;
  endfunction

  // len nonzero bytes, then a NUL, then junk or zeros; left aligned
  function automatic logic [255:0] make_text(input int nbytes, input int len, input bit junk);
    logic [255:0] r;
    r = '0;
    for (int b = 0; b < nbytes; b++) begin
      if (b < len) r[255-8*b -: 8] = 8'($urandom_range(255, 1));
      else if (b > len && junk) r[255-8*b -: 8] = 8'($urandom);
    end
    return r;
  endfunction

  function automatic logic [255:0] cut_after_nul(input logic [255:0] s, input int nbytes);
    logic         seen;
    logic [255:0] r;
    seen = 1'b0;
    r    = s;
    for (int b = 0; b < nbytes; b++) begin
      if (seen) r[255-8*b -: 8] = 8'h00;
      else if (s[255-8*b -: 8] == 8'h00) seen = 1'b1;
    end
    return r;
  endfunction

  function automatic int first_slot_named(input logic [127:0] nm);
    for (int i = 0; i < NumEntries; i++)
      if (acct_used[i] && acct_name[i] == nm) return i;
    return -1;
  endfunction

  function automatic cred_reply_t apply_request(input cred_req_t rq);
    cred_reply_t  rs;
    logic [255:0] t;
    logic [127:0] nm;
    logic [255:0] pw;
    int           hit;
    rs  = '{status: ST_FAIL, uid: '0, name: '0};
    t   = cut_after_nul({rq.name, 128'h0}, 16);
    nm  = t[255:128];
    pw  = cut_after_nul(rq.pass, 32);
    hit = -1;
    case (rq.kind)
      REQ_CHECK: begin
        hit = first_slot_named(nm);
        if (hit >= 0 && acct_pass[hit] == pw) begin
          rs.status = ST_OK;
          rs.uid    = acct_uid[hit];
        end
      end
      REQ_LOOKUP: begin
        rs.name = {TXT_UNKNOWN, 64'h0};
        for (int i = 0; i < NumEntries; i++) begin
          if (hit < 0 && acct_used[i] && acct_uid[i] == rq.uid) begin
            hit       = i;
            rs.status = ST_OK;
            rs.name   = acct_name[i];
          end
        end
      end
      REQ_ADD: begin
        for (int i = 0; i < NumEntries; i++) begin
          if (hit < 0 && !acct_used[i]) begin
            hit          = i;
            acct_used[i] = 1'b1;
            acct_uid[i]  = rq.uid;
            acct_gid[i]  = rq.gid;
            acct_name[i] = {nm[127:8], 8'h00};
            acct_pass[i] = {pw[255:8], 8'h00};
            rs.status    = ST_OK;
          end
        end
      end
      default: begin
        hit = first_slot_named(nm);
        if (hit >= 0 && acct_uid[hit] != 16'd0) begin
          acct_used[hit] = 1'b0;
          rs.status      = ST_OK;
        end
      end
    endcase
    return rs;
  endfunction

  function automatic plan_row_t drow(input req_e kind, input logic [127:0] nm,
                                     input logic [255:0] pw, input logic [15:0] uid,
                                     input logic [15:0] gid, input bit typed,
                                     input logic st, input logic [15:0] fuid,
                                     input logic [127:0] oname);
    plan_row_t r;
    r.rq    = '{kind: kind, name: nm, pass: pw, uid: uid, gid: gid};
    r.typed = typed;
    r.want  = '{status: st, uid: fuid, name: oname};
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [127:0] got,
                               input logic [127:0] want);
    $display("mismatch %s: got %h, want %h (cycle %0d)", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  task automatic offer_beat(input cred_req_t rq, input bit typed, input cred_reply_t want);
    cred_reply_t model_r;
    while (!calm() && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rq.kind;
    name_hi_i  <= rq.name[127:64];
    name_lo_i  <= rq.name[63:0];
    pass_w0_i  <= rq.pass[255:192];
    pass_w1_i  <= rq.pass[191:128];
    pass_w2_i  <= rq.pass[127:64];
    pass_w3_i  <= rq.pass[63:0];
    user_id_i  <= rq.uid;
    group_id_i <= rq.gid;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    model_r = apply_request(rq);
    awaited_replies.push_back(typed ? want : model_r);
    offered_cnt++;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, a quiet window
  always @(posedge clk_i) begin
    if (!held_once && offered_cnt >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm() && ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk_i) begin
    cred_reply_t w;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch("unexpected beat", {status_o, found_uid_o}, '0);
      end else begin
        w = awaited_replies.pop_front();
        if (status_o !== w.status) flag_mismatch("status", status_o, w.status);
        if (found_uid_o !== w.uid) flag_mismatch("found_uid", found_uid_o, w.uid);
        if (out_name_hi_o !== w.name[127:64])
          flag_mismatch("out_name_hi", out_name_hi_o, w.name[127:64]);
        if (out_name_lo_o !== w.name[63:0])
          flag_mismatch("out_name_lo", out_name_lo_o, w.name[63:0]);
      end
    end
  end

  initial begin
    cred_req_t    rq;
    cred_reply_t  none;
    logic [127:0] name_pool [8];
    logic [255:0] t;
    int           live [$];
    int           s;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_CHECK;
    name_hi_i   <= '0;
    name_lo_i   <= '0;
    pass_w0_i   <= '0;
    pass_w1_i   <= '0;
    pass_w2_i   <= '0;
    pass_w3_i   <= '0;
    user_id_i   <= '0;
    group_id_i  <= '0;
    none = '{status: ST_OK, uid: '0, name: '0};

    for (int i = 0; i < NumEntries; i++) begin
      acct_used[i] = 1'b0;
      acct_uid[i]  = '0;
      acct_gid[i]  = '0;
      acct_name[i] = '0;
      acct_pass[i] = '0;
    end
    acct_used[0] = 1'b1;
    acct_name[0] = {TXT_ROOT, 64'h0};
    acct_pass[0] = {TXT_TOOR, 192'h0};
    acct_used[1] = 1'b1;
    acct_uid[1]  = 16'd1000;
    acct_gid[1]  = 16'd1000;
    acct_name[1] = {TXT_USER, 64'h0};
    acct_pass[1] = {TXT_USER, 192'h0};

    plan.push_back(drow(REQ_CHECK, name_of("root"), secret_of("toor"), 0, 0,
                        1, ST_OK, 0, '0));
    plan.push_back(drow(REQ_CHECK, name_of("user"), secret_of("user"), 0, 0,
                        1, ST_OK, 16'd1000, '0));
    plan.push_back(drow(REQ_CHECK, name_of("root"), secret_of("toor!"), 0, 0,
                        1, ST_FAIL, 0, '0));
    plan.push_back(drow(REQ_CHECK, name_of("ghost"), secret_of("x"), 0, 0,
                        1, ST_FAIL, 0, '0));
    plan.push_back(drow(REQ_LOOKUP, '0, '0, 16'd0, 0, 1, ST_OK, 0, name_of("root")));
    plan.push_back(drow(REQ_LOOKUP, '0, '0, 16'd1000, 0, 1, ST_OK, 0, name_of("user")));
    plan.push_back(drow(REQ_LOOKUP, '0, '0, 16'hFFFF, 0, 1, ST_FAIL, 0,
                        name_of("unknown")));
    // root may never be deleted
    plan.push_back(drow(REQ_DELETE, name_of("root"), '0, 0, 0, 1, ST_FAIL, 0, '0));
    plan.push_back(drow(REQ_DELETE, name_of("ghost"), '0, 0, 0, 1, ST_FAIL, 0, '0));
    // junk after the terminator is ignored
    plan.push_back(drow(REQ_CHECK, {32'h726F6F74, 8'h00, {88{1'b1}}},
                        {32'h746F6F72, 8'h00, {216{1'b1}}}, 16'hFFFF, 16'hFFFF,
                        1, ST_OK, 0, '0));
    // overlong strings get truncated on store and never match as input
    plan.push_back(drow(REQ_ADD, '1, '1, 16'hFFFF, 16'hFFFF, 1, ST_OK, 0, '0));
    plan.push_back(drow(REQ_CHECK, '1, '1, 0, 0, 1, ST_FAIL, 0, '0));
    plan.push_back(drow(REQ_CHECK, {{120{1'b1}}, 8'h00}, {{248{1'b1}}, 8'h00}, 0, 0,
                        1, ST_OK, 16'hFFFF, '0));
    plan.push_back(drow(REQ_LOOKUP, '0, '0, 16'hFFFF, 0, 1, ST_OK, 0,
                        {{120{1'b1}}, 8'h00}));
    plan.push_back(drow(REQ_DELETE, {{120{1'b1}}, 8'h00}, '0, 0, 0, 1, ST_OK, 0, '0));
    for (int k = 0; k < NumEntries - 2; k++)
      plan.push_back(drow(REQ_ADD, name_of($sformatf("acct%0d", k)),
                          secret_of($sformatf("pw%0d", k)), 16'(k), 16'(k + 100),
                          0, ST_OK, 0, '0));
    plan.push_back(drow(REQ_ADD, name_of("extra"), secret_of("x"), 16'd7, 0,
                        1, ST_FAIL, 0, '0));
    plan.push_back(drow(REQ_DELETE, name_of("acct0"), '0, 0, 0, 1, ST_FAIL, 0, '0));
    plan.push_back(drow(REQ_DELETE, name_of("user"), '0, 0, 0, 1, ST_OK, 0, '0));

    for (int i = 0; i < 8; i++) begin
      t = make_text(16, $urandom_range(15, 1), 1'b0);
      name_pool[i] = t[255:128];
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer_beat(plan[i].rq, plan[i].typed, plan[i].want);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      live.delete();
      for (int i = 0; i < NumEntries; i++) if (acct_used[i]) live.push_back(i);
      s = (live.size() > 0) ? live[$urandom_range(live.size() - 1)] : -1;
      rq.kind = req_e'($urandom_range(3));
      rq.name = name_pool[$urandom_range(7)];
      rq.pass = make_text(32, $urandom_range(32), $urandom_range(1));
      rq.uid  = ($urandom_range(1)) ? 16'($urandom_range(20)) : 16'($urandom);
      rq.gid  = 16'($urandom);
      if ($urandom_range(99) < 15) begin
        rq.name = {$urandom, $urandom, $urandom, $urandom};
        rq.pass = {$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
        rq.uid  = 16'($urandom);
      end else begin
        case (rq.kind)
          REQ_CHECK: begin
            if (s >= 0 && $urandom_range(99) < 70) begin
              rq.name = acct_name[s];
              rq.pass = acct_pass[s];
              if ($urandom_range(3) == 0) rq.pass[$urandom_range(255)] ^= 1'b1;
            end
          end
          REQ_LOOKUP: if (s >= 0 && $urandom_range(99) < 70) rq.uid = acct_uid[s];
          REQ_ADD: if ($urandom_range(4) == 0) rq.uid = '0;
          default: if (s >= 0 && $urandom_range(99) < 60) rq.name = acct_name[s];
        endcase
      end
      offer_beat(rq, 1'b0, none);
    end
    in_valid_i <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (NumEntries + 4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
